[rtl/bsm_pkg.sv]
`default_nettype none

package bsm_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FRAME_PERIOD = 2'd0;
    localparam logic [1:0] CFG_MIN_SPEED    = 2'd1;
    localparam logic [1:0] CFG_MAX_SPEED    = 2'd2;

    localparam logic [7:0] FRAME_PERIOD_RST = 8'd13;
    localparam logic [8:0] MIN_SPEED_RST    = 9'd80;
    localparam logic [8:0] MAX_SPEED_RST    = 9'd250;

    localparam logic signed [10:0] VEL_X_RST = 11'sd180;
    localparam logic signed [10:0] VEL_Y_RST = 11'sd140;

    // Seeding of the first velocities and the jitter offset.
    localparam logic [10:0] SEED_BASE_X  = 11'd140;
    localparam logic [10:0] SEED_BASE_Y  = 11'd200;
    localparam logic [10:0] JITTER_BIAS  = 11'd16;

    typedef struct packed {
        logic [7:0] frame_period;
        logic [8:0] min_speed;
        logic [8:0] max_speed;
    } cfg_t;

    typedef struct packed {
        logic       command;
        logic [5:0] seed;
        logic       flip_x;
        logic       flip_y;
        logic [4:0] jitter_side;
        logic [4:0] jitter_floor;
    } item_t;

    typedef struct packed {
        logic              started;
        logic [15:0]       fix_x;
        logic [15:0]       fix_y;
        logic signed [10:0] vel_x;
        logic signed [10:0] vel_y;
        logic [6:0]        shown_x;
        logic [5:0]        shown_y;
        logic [7:0]        tick_count;
    } state_t;

    typedef struct packed {
        logic [6:0] pos_x;
        logic [5:0] pos_y;
        logic       corner_hit;
    } result_t;

endpackage

`default_nettype wire

[rtl/bsm_step.sv]
`default_nettype none

module bsm_step #(
    parameter int SCREEN_W = 128,
    parameter int SCREEN_H = 64,
    parameter int SPRITE_W = 48,
    parameter int SPRITE_H = 24
) (
    input  bsm_pkg::cfg_t    cfg,
    input  bsm_pkg::state_t  state,
    input  bsm_pkg::item_t   item,
    output bsm_pkg::state_t  state_next,
    output bsm_pkg::result_t result,
    output logic             result_valid
);

    localparam int SPAN_X = (SCREEN_W > SPRITE_W) ? SCREEN_W - SPRITE_W : 0;
    localparam int SPAN_Y = (SCREEN_H > SPRITE_H) ? SCREEN_H - SPRITE_H : 0;
    localparam logic signed [17:0] MAX_FX = 18'(SPAN_X * 256);
    localparam logic signed [17:0] MAX_FY = 18'(SPAN_Y * 256);
    localparam logic [15:0] CENTRE_FX = 16'((SPAN_X / 2) * 256);
    localparam logic [15:0] CENTRE_FY = 16'((SPAN_Y / 2) * 256);
    localparam logic [6:0]  CENTRE_X  = 7'(SPAN_X / 2);
    localparam logic [5:0]  CENTRE_Y  = 6'(SPAN_Y / 2);

    // Min clamp first, then max clamp, so min above max ends at max.
    function automatic logic signed [10:0] clamp_speed(
        input logic signed [10:0] v,
        input logic [8:0]         lo,
        input logic [8:0]         hi
    );
        logic signed [10:0] lo_s;
        logic signed [10:0] hi_s;
        logic signed [10:0] r;
        lo_s = $signed({2'b00, lo});
        hi_s = $signed({2'b00, hi});
        r    = v;
        if (r > 11'sd0 && r < lo_s) r = lo_s;
        if (r < 11'sd0 && r > -lo_s) r = -lo_s;
        if (r > hi_s) r = hi_s;
        if (r < -hi_s) r = -hi_s;
        return r;
    endfunction

    logic [7:0]         period;
    logic [7:0]         tick_inc;
    logic signed [10:0] jit_side;
    logic signed [10:0] jit_floor;
    logic signed [10:0] seed_vx;
    logic signed [10:0] seed_vy;
    logic signed [17:0] fx;
    logic signed [17:0] fy;
    logic signed [10:0] vx;
    logic signed [10:0] vy;
    logic               hit_x;
    logic               hit_y;
    logic [6:0]         nx;
    logic [5:0]         ny;

    assign period    = (cfg.frame_period == 8'd0) ? 8'd1 : cfg.frame_period;
    assign tick_inc  = state.tick_count + 8'd1;
    assign jit_side  = $signed({6'b0, item.jitter_side} - bsm_pkg::JITTER_BIAS);
    assign jit_floor = $signed({6'b0, item.jitter_floor} - bsm_pkg::JITTER_BIAS);
    assign seed_vx   = $signed(bsm_pkg::SEED_BASE_X + {5'b0, item.seed});
    assign seed_vy   = $signed(bsm_pkg::SEED_BASE_Y - {5'b0, item.seed});

    // Motion frame: advance, clamp at each wall in turn, then limit the speeds.
    always_comb begin
        fx    = $signed({2'b00, state.fix_x}) + 18'(state.vel_x);
        fy    = $signed({2'b00, state.fix_y}) + 18'(state.vel_y);
        vx    = state.vel_x;
        vy    = state.vel_y;
        hit_x = 1'b0;
        hit_y = 1'b0;
        if (fx <= 18'sd0) begin
            fx    = 18'sd0;
            vx    = -vx;
            vy    = vy + jit_side;
            hit_x = 1'b1;
        end
        if (fx >= MAX_FX) begin
            fx    = MAX_FX;
            vx    = -vx;
            vy    = vy + jit_side;
            hit_x = 1'b1;
        end
        if (fy <= 18'sd0) begin
            fy    = 18'sd0;
            vy    = -vy;
            vx    = vx + jit_floor;
            hit_y = 1'b1;
        end
        if (fy >= MAX_FY) begin
            fy    = MAX_FY;
            vy    = -vy;
            vx    = vx + jit_floor;
            hit_y = 1'b1;
        end
        vx = clamp_speed(vx, cfg.min_speed, cfg.max_speed);
        vy = clamp_speed(vy, cfg.min_speed, cfg.max_speed);
    end

    assign nx = fx[14:8];
    assign ny = fy[13:8];

    always_comb begin
        state_next   = state;
        result       = '0;
        result_valid = 1'b0;
        if (item.command) begin
            state_next.started = 1'b0;
        end else if (!state.started) begin
            state_next.started    = 1'b1;
            state_next.shown_x    = CENTRE_X;
            state_next.shown_y    = CENTRE_Y;
            state_next.fix_x      = CENTRE_FX;
            state_next.fix_y      = CENTRE_FY;
            state_next.vel_x      = item.flip_x ? -seed_vx : seed_vx;
            state_next.vel_y      = item.flip_y ? -seed_vy : seed_vy;
            state_next.tick_count = 8'd0;
            result.pos_x          = CENTRE_X;
            result.pos_y          = CENTRE_Y;
            result_valid          = 1'b1;
        end else if (tick_inc < period) begin
            state_next.tick_count = tick_inc;
        end else begin
            state_next.tick_count = 8'd0;
            state_next.fix_x      = fx[15:0];
            state_next.fix_y      = fy[15:0];
            state_next.vel_x      = vx;
            state_next.vel_y      = vy;
            if (nx != state.shown_x || ny != state.shown_y) begin
                state_next.shown_x = nx;
                state_next.shown_y = ny;
                result.pos_x       = nx;
                result.pos_y       = ny;
                result.corner_hit  = hit_x && hit_y;
                result_valid       = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/bouncing_sprite_motion.sv]
`default_nettype none

// Bouncing sprite motion. Each input transaction is a millisecond tick or a
// restart; the block keeps the sprite's 8.8 fixed-point position and velocity,
// runs a motion frame every frame_period ticks and sends a result transaction
// only when the integer position changes (always on the first tick after reset
// or restart, which centres the sprite). One transaction is taken per clock:
// it is held in an input register, worked through a single pass of add,
// compare and clamp logic and written to the output register, so a result
// is offered on the output from the output register, not from the step logic. The output
// register lets the next tick be accepted while a result waits; input stalls
// only when both the input and output registers are full and the result side
// is stalled. Configuration writes take effect at once and should be made
// while idle.
module bouncing_sprite_motion #(
    parameter int SCREEN_W = 128,
    parameter int SCREEN_H = 64,
    parameter int SPRITE_W = 48,
    parameter int SPRITE_H = 24
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,

    input  wire logic       cfg_wr_en,
    input  wire logic [1:0] cfg_index,
    input  wire logic [8:0] cfg_data,

    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_command,
    input  wire logic [5:0] s_seed,
    input  wire logic       s_flip_x,
    input  wire logic       s_flip_y,
    input  wire logic [4:0] s_jitter_side,
    input  wire logic [4:0] s_jitter_floor,

    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [6:0]      m_pos_x,
    output logic [5:0]      m_pos_y,
    output logic            m_corner_hit
);

    localparam int SPAN_X = (SCREEN_W > SPRITE_W) ? SCREEN_W - SPRITE_W : 0;
    localparam int SPAN_Y = (SCREEN_H > SPRITE_H) ? SCREEN_H - SPRITE_H : 0;
    localparam logic [15:0] MAX_FX = 16'(SPAN_X * 256);
    localparam logic [15:0] MAX_FY = 16'(SPAN_Y * 256);
    localparam logic [6:0]  EDGE_X = 7'(SPAN_X);
    localparam logic [5:0]  EDGE_Y = 6'(SPAN_Y);

    bsm_pkg::cfg_t    cfg_reg;
    bsm_pkg::state_t  state_reg;
    bsm_pkg::state_t  state_next;
    bsm_pkg::item_t   item_reg;
    bsm_pkg::result_t result_reg;
    bsm_pkg::result_t result_next;
    logic             in_valid_reg;
    logic             out_valid_reg;
    logic             result_valid;
    logic             advance;

    // The held transaction moves on whenever the output register can take it.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_period <= bsm_pkg::FRAME_PERIOD_RST;
            cfg_reg.min_speed    <= bsm_pkg::MIN_SPEED_RST;
            cfg_reg.max_speed    <= bsm_pkg::MAX_SPEED_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bsm_pkg::CFG_FRAME_PERIOD: cfg_reg.frame_period <= cfg_data[7:0];
                bsm_pkg::CFG_MIN_SPEED:    cfg_reg.min_speed    <= cfg_data;
                bsm_pkg::CFG_MAX_SPEED:    cfg_reg.max_speed    <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            item_reg.command      <= s_command;
            item_reg.seed         <= s_seed;
            item_reg.flip_x       <= s_flip_x;
            item_reg.flip_y       <= s_flip_y;
            item_reg.jitter_side  <= s_jitter_side;
            item_reg.jitter_floor <= s_jitter_floor;
        end
    end

    bsm_step #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H),
        .SPRITE_W (SPRITE_W),
        .SPRITE_H (SPRITE_H)
    ) u_step (
        .cfg          (cfg_reg),
        .state        (state_reg),
        .item         (item_reg),
        .state_next   (state_next),
        .result       (result_next),
        .result_valid (result_valid)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.started    <= 1'b0;
            state_reg.fix_x      <= '0;
            state_reg.fix_y      <= '0;
            state_reg.vel_x      <= bsm_pkg::VEL_X_RST;
            state_reg.vel_y      <= bsm_pkg::VEL_Y_RST;
            state_reg.shown_x    <= '0;
            state_reg.shown_y    <= '0;
            state_reg.tick_count <= '0;
            out_valid_reg        <= 1'b0;
        end else begin
            if (advance) begin
                state_reg     <= state_next;
                out_valid_reg <= result_valid;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (advance && result_valid) begin
            result_reg <= result_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_pos_x      = result_reg.pos_x;
    assign m_pos_y      = result_reg.pos_y;
    assign m_corner_hit = result_reg.corner_hit;

    a_fix_x_in_span: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.fix_x <= MAX_FX)
        else $error("horizontal position left the travel span");

    a_fix_y_in_span: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.fix_y <= MAX_FY)
        else $error("vertical position left the travel span");

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |=> in_valid_reg)
        else $error("held transaction lost while the output was stalled");

    a_corner_at_wall: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && result_reg.corner_hit) |->
            ((result_reg.pos_x == 7'd0 || result_reg.pos_x == EDGE_X) &&
             (result_reg.pos_y == 6'd0 || result_reg.pos_y == EDGE_Y)))
        else $error("corner hit reported away from a corner");

endmodule

`default_nettype wire
